// File: rtl/core/fodd_pkg.sv
// shared constants, types and state encoding for the duplicate filter
`timescale 1ns / 1ps
`default_nettype none
package fodd_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_W     = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_CNT_W   = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } fodd_state_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic scan_step;
    logic finish;
  } fodd_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic match;
    logic scan_end;
    logic out_free;
  } fodd_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/fodd_if.sv
// request channel interfaces for input elements and results
`timescale 1ns / 1ps
`default_nettype none
interface fodd_in_if
  import fodd_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface fodd_out_if
  import fodd_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic                      keep;
  logic [OUT_CNT_W-1:0]      distinct_count;
  logic                      overflow;
  logic                      out_last;

  modport source (output valid, output out_value, output keep, output distinct_count,
                  output overflow, output out_last, input ready);
  modport sink (input valid, input out_value, input keep, input distinct_count,
                input overflow, input out_last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/fodd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module fodd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fodd_ctrl.sv
// controller state machine sequencing load, table scan and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module fodd_ctrl
  import fodd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire fodd_sts_t sts,
  output fodd_cmd_t      cmd
);

  fodd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.count_zero ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.match || sts.scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_DONE: begin
        cmd.finish = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  a_scan_leads_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && (sts.match || sts.scan_end)) |=> state_r == ST_DONE)
    else $error("scan did not stop on match or end");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_SCAN || state_r == ST_DONE))
    else $error("load did not start processing");

  a_finish_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == ST_IDLE)
    else $error("finish did not return to idle");

endmodule
`default_nettype wire

// File: rtl/core/fodd_dp.sv
// datapath: request latch, scan index, distinct count, compare and result register
`timescale 1ns / 1ps
`default_nettype none
module fodd_dp
  import fodd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire fodd_cmd_t                 cmd,
  output fodd_sts_t                      sts,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic                      in_last,
  output logic                           ram_we,
  output logic [IDX_W-1:0]               ram_waddr,
  output logic [VALUE_W-1:0]             ram_wdata,
  output logic                           ram_re,
  output logic [IDX_W-1:0]               ram_raddr,
  input  wire logic [VALUE_W-1:0]        ram_rdata,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [VALUE_W-1:0]      out_value,
  output logic                           out_keep,
  output logic [OUT_CNT_W-1:0]           out_distinct_count,
  output logic                           out_overflow,
  output logic                           out_last
);

  logic signed [VALUE_W-1:0] value_r;
  logic                      last_r;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic                      hit_r, hit_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r;
  logic                      out_keep_r, out_overflow_r, out_last_r;
  logic [OUT_CNT_W-1:0]      out_count_r;
  logic                      full;
  logic                      keep_new;
  logic [CNT_W-1:0]          count_after;

  assign full        = (count_r == CNT_W'(TABLE_DEPTH));
  assign keep_new    = !hit_r && !full;
  assign count_after = keep_new ? count_r + CNT_W'(1) : count_r;

  assign sts.count_zero = (count_r == '0);
  assign sts.match      = (ram_rdata == VALUE_W'(value_r));
  assign sts.scan_end   = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  // read address runs one ahead of the compare
  assign ram_re    = cmd.load || cmd.scan_step;
  assign ram_raddr = cmd.load ? '0 : IDX_W'(idx_r + IDX_W'(1));
  assign ram_we    = cmd.finish && keep_new;
  assign ram_waddr = IDX_W'(count_r);
  assign ram_wdata = VALUE_W'(value_r);

  always_comb begin
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      idx_nxt = '0;
      hit_nxt = 1'b0;
    end else if (cmd.scan_step) begin
      idx_nxt = IDX_W'(idx_r + IDX_W'(1));
      hit_nxt = sts.match;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      count_nxt     = last_r ? '0 : count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      idx_r       <= '0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
      last_r  <= in_last;
    end
    if (cmd.finish) begin
      out_value_r    <= value_r;
      out_keep_r     <= keep_new;
      out_overflow_r <= !hit_r && full;
      out_count_r    <= OUT_CNT_W'(count_after);
      out_last_r     <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_keep           = out_keep_r;
  assign out_distinct_count = out_count_r;
  assign out_overflow       = out_overflow_r;
  assign out_last           = out_last_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("distinct count above table depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (CNT_W'(idx_r) < count_r))
    else $error("scan reached an unwritten entry");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && keep_new && !last_r) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("kept value did not advance the count");

  a_keep_overflow_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_keep_r && out_overflow_r))
    else $error("keep and overflow both set");

endmodule
`default_nettype wire

// File: rtl/core/first_occurrence_dedup_filter_core.sv
// top level of the first-occurrence duplicate filter
//
// usage: array elements enter on in_ch one request each, last set on the
// final element of an array. every request gives exactly one result on
// out_ch: the element, keep (first occurrence, now stored), the distinct
// count so far, overflow (new value dropped, table full) and out_last.
// the table holds TABLE_DEPTH values in a single-port-write ram; an element
// is compared against the stored values one entry per cycle.
// sequence: the element is taken in the idle state, then the stored values
// are scanned (stopping early on a match, skipped while the count is zero),
// then the table is written and the result register loaded, which waits
// for the output register to be free. the result appears the cycle after that.
// the next request is taken while the result still waits in the output
// register; its own result waits for the register to empty.
// reset clears the count and the output valid; table contents need no
// clearing, only entries below the count are ever compared. after the last
// element the count returns to zero.
`timescale 1ns / 1ps
`default_nettype none
module first_occurrence_dedup_filter_core
  import fodd_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  fodd_in_if.sink   in_ch,
  fodd_out_if.source out_ch
);

  fodd_cmd_t          cmd;
  fodd_sts_t          sts;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  assign in_ch.ready = cmd.in_ready;

  fodd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  fodd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_value           (in_ch.value),
    .in_last            (in_ch.last),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_re             (ram_re),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_value          (out_ch.out_value),
    .out_keep           (out_ch.keep),
    .out_distinct_count (out_ch.distinct_count),
    .out_overflow       (out_ch.overflow),
    .out_last           (out_ch.out_last)
  );

  fodd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire
